>>> rtl/core/ts_packet_field_parser_assert.svh
// Assertion macros used by the transport stream field parser checker
`ifndef TS_PACKET_FIELD_PARSER_ASSERT_SVH
`define TS_PACKET_FIELD_PARSER_ASSERT_SVH

// Checked only outside reset
`define TPFP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included
`define TPFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/ts_pfp_pkg.sv
// Types, parse phases and field codes of the transport stream field parser
package ts_pfp_pkg;

    localparam int unsigned MAX_RESULTS = 8;
    localparam logic [7:0] MIN_PACKET_BYTES = 8'd188;
    localparam logic [7:0] MAX_PACKET_BYTES = 8'd255;
    localparam logic [7:0] SYNC_BYTE = 8'h47;

    // Parse phases
    localparam logic [5:0] PH_IDLE     = 6'd0;
    localparam logic [5:0] PH_HDR1     = 6'd1;
    localparam logic [5:0] PH_HDR2     = 6'd2;
    localparam logic [5:0] PH_HDR3     = 6'd3;
    localparam logic [5:0] PH_AFLEN    = 6'd4;
    localparam logic [5:0] PH_AFFLAGS  = 6'd5;
    localparam logic [5:0] PH_PCR0     = 6'd6;
    localparam logic [5:0] PH_PCR1     = 6'd7;
    localparam logic [5:0] PH_PCR2     = 6'd8;
    localparam logic [5:0] PH_PCR3     = 6'd9;
    localparam logic [5:0] PH_PCR4     = 6'd10;
    localparam logic [5:0] PH_PCR5     = 6'd11;
    localparam logic [5:0] PH_OPCR0    = 6'd12;
    localparam logic [5:0] PH_OPCR1    = 6'd13;
    localparam logic [5:0] PH_OPCR2    = 6'd14;
    localparam logic [5:0] PH_OPCR3    = 6'd15;
    localparam logic [5:0] PH_OPCR4    = 6'd16;
    localparam logic [5:0] PH_OPCR5    = 6'd17;
    localparam logic [5:0] PH_SPLICE   = 6'd18;
    localparam logic [5:0] PH_PRIVLEN  = 6'd19;
    localparam logic [5:0] PH_PRIVDATA = 6'd20;
    localparam logic [5:0] PH_EXTLEN   = 6'd21;
    localparam logic [5:0] PH_EXTFLAGS = 6'd22;
    localparam logic [5:0] PH_LTW0     = 6'd23;
    localparam logic [5:0] PH_LTW1     = 6'd24;
    localparam logic [5:0] PH_PIECE0   = 6'd25;
    localparam logic [5:0] PH_PIECE1   = 6'd26;
    localparam logic [5:0] PH_PIECE2   = 6'd27;
    localparam logic [5:0] PH_DTS0     = 6'd28;
    localparam logic [5:0] PH_DTS1     = 6'd29;
    localparam logic [5:0] PH_DTS2     = 6'd30;
    localparam logic [5:0] PH_DTS3     = 6'd31;
    localparam logic [5:0] PH_DTS4     = 6'd32;
    localparam logic [5:0] PH_EXTRES   = 6'd33;
    localparam logic [5:0] PH_STUFF    = 6'd34;
    localparam logic [5:0] PH_BODY     = 6'd35;

    // Field codes
    localparam logic [5:0] FC_SYNC      = 6'd0;
    localparam logic [5:0] FC_TEI       = 6'd1;
    localparam logic [5:0] FC_PUSI      = 6'd2;
    localparam logic [5:0] FC_PRIO      = 6'd3;
    localparam logic [5:0] FC_PID       = 6'd4;
    localparam logic [5:0] FC_SCRAMBLE  = 6'd5;
    localparam logic [5:0] FC_AFC       = 6'd6;
    localparam logic [5:0] FC_CC        = 6'd7;
    localparam logic [5:0] FC_AF_LEN    = 6'd8;
    localparam logic [5:0] FC_AF_FLAG0  = 6'd9;
    localparam logic [5:0] FC_PCR_BASE  = 6'd17;
    localparam logic [5:0] FC_OPCR_BASE = 6'd19;
    localparam logic [5:0] FC_SPLICE    = 6'd21;
    localparam logic [5:0] FC_PRIV_LEN  = 6'd22;
    localparam logic [5:0] FC_PRIV_DATA = 6'd23;
    localparam logic [5:0] FC_EXT_LEN   = 6'd24;
    localparam logic [5:0] FC_LTW_FLAG  = 6'd25;
    localparam logic [5:0] FC_PIECE_FLG = 6'd26;
    localparam logic [5:0] FC_SEAM_FLAG = 6'd27;
    localparam logic [5:0] FC_LTW_VALID = 6'd28;
    localparam logic [5:0] FC_LTW_OFFS  = 6'd29;
    localparam logic [5:0] FC_PIECE     = 6'd30;
    localparam logic [5:0] FC_SPL_TYPE  = 6'd31;
    localparam logic [5:0] FC_DTS_HI    = 6'd32;
    localparam logic [5:0] FC_MARK0     = 6'd33;
    localparam logic [5:0] FC_DTS_MID   = 6'd34;
    localparam logic [5:0] FC_MARK1     = 6'd35;
    localparam logic [5:0] FC_DTS_LO    = 6'd36;
    localparam logic [5:0] FC_MARK2     = 6'd37;
    localparam logic [5:0] FC_PAYLOAD   = 6'd38;
    localparam logic [5:0] FC_SYNC_ERR  = 6'd39;

    typedef struct packed {
        logic [5:0]  code;
        logic [32:0] value;
        logic [10:0] offset;
        logic [10:0] length;
    } field_t;

    typedef struct packed {
        field_t [MAX_RESULTS-1:0] fields;
        logic [3:0]               count;
    } run_t;

    // First optional adaptation section at or after slot k
    function automatic logic [5:0] next_adapt(input logic [7:0] flags, input int k);
        logic [5:0] ph;
        ph = PH_STUFF;
        if (k <= 4 && flags[0]) ph = PH_EXTLEN;
        if (k <= 3 && flags[1]) ph = PH_PRIVLEN;
        if (k <= 2 && flags[2]) ph = PH_SPLICE;
        if (k <= 1 && flags[3]) ph = PH_OPCR0;
        if (k <= 0 && flags[4]) ph = PH_PCR0;
        return ph;
    endfunction

    // First optional extension section at or after slot k
    function automatic logic [5:0] next_ext(input logic [2:0] flags, input int k);
        logic [5:0] ph;
        ph = PH_EXTRES;
        if (k <= 2 && flags[0]) ph = PH_DTS0;
        if (k <= 1 && flags[1]) ph = PH_PIECE0;
        if (k <= 0 && flags[2]) ph = PH_LTW0;
        return ph;
    endfunction

    function automatic field_t mk(input logic [5:0] c, input logic [32:0] v,
                                  input logic [10:0] o, input logic [10:0] l);
        field_t f;
        f.code = c;
        f.value = v;
        f.offset = o;
        f.length = l;
        return f;
    endfunction

endpackage

>>> rtl/core/ts_packet_field_parser.sv
// Transport stream packet field parser: one packet byte per word in, one decoded
// field per word out. A byte is decoded in the cycle it is accepted and its fields
// (zero to eight) land in a result buffer that drains one word per cycle while
// m_ready is high; a new byte is taken in the same cycle the buffer's last field
// leaves, or while the buffer is empty. Packet size starts at 188 after reset.
module ts_packet_field_parser #(
    parameter logic [7:0] MAX_PACKET_BYTES = ts_pfp_pkg::MAX_PACKET_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_packet_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_field_code,
    output logic [32:0] m_field_value,
    output logic [10:0] m_bit_offset,
    output logic [10:0] m_bit_length,
    output logic        m_last_of_run
);

    ts_pfp_pkg::run_t   run;
    ts_pfp_pkg::field_t head;
    logic               accept;
    logic               free;

    assign s_ready = free;
    assign accept  = s_valid && free;

    // Byte decode and parse state
    ts_pfp_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .accept       (accept),
        .data_byte    (s_data_byte),
        .packet_start (s_packet_start),
        .run          (run)
    );

    // Field buffer and output
    ts_pfp_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept),
        .run     (run),
        .free    (free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head),
        .last    (m_last_of_run)
    );

    assign m_field_code  = head.code;
    assign m_field_value = head.value;
    assign m_bit_offset  = head.offset;
    assign m_bit_length  = head.length;

endmodule

>>> rtl/core/ts_pfp_parser.sv
// Parse state, packet size register and per-byte field decode
module ts_pfp_parser #(
    parameter logic [7:0] MAX_PACKET_BYTES = ts_pfp_pkg::MAX_PACKET_BYTES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               accept,
    input  logic [7:0]         data_byte,
    input  logic               packet_start,
    output ts_pfp_pkg::run_t   run
);

    logic [7:0]  psize_reg, psize_next;
    logic [7:0]  pos_reg, pos_next;
    logic [5:0]  phase_reg, phase_next;
    logic [39:0] acc_reg, acc_next;
    logic [7:0]  aflags_reg, aflags_next;
    logic [2:0]  eflags_reg, eflags_next;
    logic [1:0]  ctl_reg, ctl_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  poff_reg, poff_next;

    logic [5:0]  ph;
    logic [7:0]  p;
    logic [10:0] p8;
    logic [10:0] s;
    logic [39:0] shifted;
    logic [8:0]  poff_sum;
    logic [7:0]  remain;

    // Clamped packet size register
    always_comb begin
        psize_next = psize_reg;
        if (cfg_wr_en) begin
            if (cfg_wr_data < ts_pfp_pkg::MIN_PACKET_BYTES) begin
                psize_next = ts_pfp_pkg::MIN_PACKET_BYTES;
            end else if (cfg_wr_data > MAX_PACKET_BYTES) begin
                psize_next = MAX_PACKET_BYTES;
            end else begin
                psize_next = cfg_wr_data;
            end
        end
    end

    // Decode one byte into its fields and the next parse state
    always_comb begin
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        aflags_next = aflags_reg;
        eflags_next = eflags_reg;
        ctl_next    = ctl_reg;
        left_next   = left_reg;
        poff_next   = poff_reg;
        run         = '0;
        p           = pos_reg;
        p8          = {p, 3'b000};
        s           = '0;
        shifted     = {acc_reg[31:0], data_byte};
        poff_sum    = 9'd5 + {1'b0, data_byte};
        remain      = psize_reg - p;
        ph          = phase_reg;

        if (packet_start) begin
            acc_next    = '0;
            aflags_next = '0;
            eflags_next = '0;
            ctl_next    = '0;
            left_next   = '0;
            poff_next   = 8'd4;
            run.count   = 4'd1;
            if (data_byte != ts_pfp_pkg::SYNC_BYTE) begin
                run.fields[0] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_SYNC_ERR, {25'd0, data_byte},
                                               11'd0, 11'd8);
                phase_next = ts_pfp_pkg::PH_IDLE;
                pos_next   = 8'd0;
            end else begin
                run.fields[0] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_SYNC, {25'd0, data_byte},
                                               11'd0, 11'd8);
                phase_next = ts_pfp_pkg::PH_HDR1;
                pos_next   = 8'd1;
            end
        end else if (phase_reg != ts_pfp_pkg::PH_IDLE) begin
            // Section ends that override the stored phase
            if (ph >= ts_pfp_pkg::PH_AFFLAGS && ph < ts_pfp_pkg::PH_BODY && p >= poff_reg) begin
                ph = ts_pfp_pkg::PH_BODY;
            end
            if (ph == ts_pfp_pkg::PH_PRIVDATA && left_reg == 8'd0) begin
                ph = ts_pfp_pkg::next_adapt(aflags_reg, 4);
            end
            if (ph >= ts_pfp_pkg::PH_EXTFLAGS && ph <= ts_pfp_pkg::PH_EXTRES) begin
                if (left_reg == 8'd0) begin
                    ph = ts_pfp_pkg::PH_STUFF;
                end else begin
                    left_next = left_reg - 8'd1;
                end
            end
            phase_next = ph;

            unique case (ph)
                ts_pfp_pkg::PH_HDR1: begin
                    run.fields[0] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_TEI, {32'd0, data_byte[7]},
                                                   11'd8, 11'd1);
                    run.fields[1] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_PUSI, {32'd0, data_byte[6]},
                                                   11'd9, 11'd1);
                    run.fields[2] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_PRIO, {32'd0, data_byte[5]},
                                                   11'd10, 11'd1);
                    run.count  = 4'd3;
                    acc_next   = {35'd0, data_byte[4:0]};
                    phase_next = ts_pfp_pkg::PH_HDR2;
                end
                ts_pfp_pkg::PH_HDR2: begin
                    run.fields[0] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_PID,
                                                   {20'd0, acc_reg[4:0], data_byte},
                                                   11'd11, 11'd13);
                    run.count  = 4'd1;
                    phase_next = ts_pfp_pkg::PH_HDR3;
                end
                ts_pfp_pkg::PH_HDR3: begin
                    ctl_next = data_byte[5:4];
                    run.fields[0] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_SCRAMBLE,
                                                   {31'd0, data_byte[7:6]}, 11'd24, 11'd2);
                    run.fields[1] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_AFC,
                                                   {31'd0, data_byte[5:4]}, 11'd26, 11'd2);
                    run.fields[2] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_CC,
                                                   {29'd0, data_byte[3:0]}, 11'd28, 11'd4);
                    run.count = 4'd3;
                    if (data_byte[5]) begin
                        phase_next = ts_pfp_pkg::PH_AFLEN;
                    end else begin
                        poff_next  = 8'd4;
                        phase_next = ts_pfp_pkg::PH_BODY;
                    end
                end
                ts_pfp_pkg::PH_AFLEN: begin
                    run.fields[0] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_AF_LEN, {25'd0, data_byte},
                                                   11'd32, 11'd8);
                    run.count = 4'd1;
                    // Adaptation end saturates at the packet end
                    if (poff_sum > {1'b0, psize_reg}) begin
                        poff_next = psize_reg;
                    end else begin
                        poff_next = poff_sum[7:0];
                    end
                    phase_next = (data_byte != 8'd0) ? ts_pfp_pkg::PH_AFFLAGS
                                                     : ts_pfp_pkg::PH_BODY;
                end
                ts_pfp_pkg::PH_AFFLAGS: begin
                    aflags_next = data_byte;
                    for (int i = 0; i < 8; i++) begin
                        run.fields[i] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_AF_FLAG0 + 6'(i),
                                                       {32'd0, data_byte[7-i]},
                                                       p8 + 11'(i), 11'd1);
                    end
                    run.count  = 4'd8;
                    phase_next = ts_pfp_pkg::next_adapt(data_byte, 0);
                end
                ts_pfp_pkg::PH_PCR0, ts_pfp_pkg::PH_OPCR0, ts_pfp_pkg::PH_LTW0,
                ts_pfp_pkg::PH_PIECE0, ts_pfp_pkg::PH_DTS0: begin
                    acc_next   = {32'd0, data_byte};
                    phase_next = ph + 6'd1;
                end
                ts_pfp_pkg::PH_PCR1, ts_pfp_pkg::PH_PCR2, ts_pfp_pkg::PH_PCR3,
                ts_pfp_pkg::PH_PCR4, ts_pfp_pkg::PH_OPCR1, ts_pfp_pkg::PH_OPCR2,
                ts_pfp_pkg::PH_OPCR3, ts_pfp_pkg::PH_OPCR4, ts_pfp_pkg::PH_PIECE1,
                ts_pfp_pkg::PH_DTS1, ts_pfp_pkg::PH_DTS2, ts_pfp_pkg::PH_DTS3: begin
                    acc_next   = shifted;
                    phase_next = ph + 6'd1;
                end
                ts_pfp_pkg::PH_PCR5, ts_pfp_pkg::PH_OPCR5: begin
                    s = p8 - 11'd40;
                    run.fields[0] = ts_pfp_pkg::mk(
                        (ph == ts_pfp_pkg::PH_PCR5) ? ts_pfp_pkg::FC_PCR_BASE
                                                    : ts_pfp_pkg::FC_OPCR_BASE,
                        acc_reg[39:7], s, 11'd33);
                    run.fields[1] = ts_pfp_pkg::mk(
                        (ph == ts_pfp_pkg::PH_PCR5) ? ts_pfp_pkg::FC_PCR_BASE + 6'd1
                                                    : ts_pfp_pkg::FC_OPCR_BASE + 6'd1,
                        {24'd0, acc_reg[0], data_byte}, s + 11'd39, 11'd9);
                    run.count  = 4'd2;
                    phase_next = (ph == ts_pfp_pkg::PH_PCR5)
                                 ? ts_pfp_pkg::next_adapt(aflags_reg, 1)
                                 : ts_pfp_pkg::next_adapt(aflags_reg, 2);
                end
                ts_pfp_pkg::PH_SPLICE: begin
                    run.fields[0] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_SPLICE, {25'd0, data_byte},
                                                   p8, 11'd8);
                    run.count  = 4'd1;
                    phase_next = ts_pfp_pkg::next_adapt(aflags_reg, 3);
                end
                ts_pfp_pkg::PH_PRIVLEN: begin
                    run.fields[0] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_PRIV_LEN, {25'd0, data_byte},
                                                   p8, 11'd8);
                    run.fields[1] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_PRIV_DATA,
                                                   {25'd0, data_byte}, p8 + 11'd8,
                                                   {data_byte, 3'b000});
                    run.count  = 4'd2;
                    left_next  = data_byte;
                    phase_next = ts_pfp_pkg::PH_PRIVDATA;
                end
                ts_pfp_pkg::PH_PRIVDATA: begin
                    left_next = left_reg - 8'd1;
                end
                ts_pfp_pkg::PH_EXTLEN: begin
                    run.fields[0] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_EXT_LEN, {25'd0, data_byte},
                                                   p8, 11'd8);
                    run.count  = 4'd1;
                    left_next  = data_byte;
                    phase_next = (data_byte != 8'd0) ? ts_pfp_pkg::PH_EXTFLAGS
                                                     : ts_pfp_pkg::PH_STUFF;
                end
                ts_pfp_pkg::PH_EXTFLAGS: begin
                    eflags_next = data_byte[7:5];
                    run.fields[0] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_LTW_FLAG,
                                                   {32'd0, data_byte[7]}, p8, 11'd1);
                    run.fields[1] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_PIECE_FLG,
                                                   {32'd0, data_byte[6]}, p8 + 11'd1, 11'd1);
                    run.fields[2] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_SEAM_FLAG,
                                                   {32'd0, data_byte[5]}, p8 + 11'd2, 11'd1);
                    run.count  = 4'd3;
                    phase_next = ts_pfp_pkg::next_ext(data_byte[7:5], 0);
                end
                ts_pfp_pkg::PH_LTW1: begin
                    s = p8 - 11'd8;
                    run.fields[0] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_LTW_VALID,
                                                   {32'd0, acc_reg[7]}, s, 11'd1);
                    run.fields[1] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_LTW_OFFS,
                                                   {18'd0, acc_reg[6:0], data_byte},
                                                   s + 11'd1, 11'd15);
                    run.count  = 4'd2;
                    phase_next = ts_pfp_pkg::next_ext(eflags_reg, 1);
                end
                ts_pfp_pkg::PH_PIECE2: begin
                    run.fields[0] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_PIECE,
                                                   {11'd0, acc_reg[13:0], data_byte},
                                                   p8 - 11'd14, 11'd22);
                    run.count  = 4'd1;
                    phase_next = ts_pfp_pkg::next_ext(eflags_reg, 2);
                end
                ts_pfp_pkg::PH_DTS4: begin
                    s = p8 - 11'd32;
                    run.fields[0] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_SPL_TYPE,
                                                   {29'd0, shifted[39:36]}, s, 11'd4);
                    run.fields[1] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_DTS_HI,
                                                   {30'd0, shifted[35:33]}, s + 11'd4, 11'd3);
                    run.fields[2] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_MARK0,
                                                   {32'd0, shifted[32]}, s + 11'd7, 11'd1);
                    run.fields[3] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_DTS_MID,
                                                   {18'd0, shifted[31:17]}, s + 11'd8, 11'd15);
                    run.fields[4] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_MARK1,
                                                   {32'd0, shifted[16]}, s + 11'd23, 11'd1);
                    run.fields[5] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_DTS_LO,
                                                   {18'd0, shifted[15:1]}, s + 11'd24, 11'd15);
                    run.fields[6] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_MARK2,
                                                   {32'd0, shifted[0]}, s + 11'd39, 11'd1);
                    run.count  = 4'd7;
                    phase_next = ts_pfp_pkg::PH_EXTRES;
                end
                ts_pfp_pkg::PH_BODY: begin
                    // Payload descriptor at its first byte
                    if (p == poff_reg && ctl_reg[0] && p < psize_reg) begin
                        run.fields[0] = ts_pfp_pkg::mk(ts_pfp_pkg::FC_PAYLOAD, 33'd0, p8,
                                                       {remain, 3'b000});
                        run.count = 4'd1;
                    end
                end
                default: begin
                end
            endcase

            // Packet end
            pos_next = p + 8'd1;
            if ({1'b0, p} + 9'd1 >= {1'b0, psize_reg} || p == 8'hFF) begin
                phase_next = ts_pfp_pkg::PH_IDLE;
            end
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            psize_reg <= ts_pfp_pkg::MIN_PACKET_BYTES;
        end else begin
            psize_reg <= psize_next;
        end
    end

    // Parse state, advanced on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            phase_reg  <= ts_pfp_pkg::PH_IDLE;
            acc_reg    <= '0;
            aflags_reg <= '0;
            eflags_reg <= '0;
            ctl_reg    <= '0;
            left_reg   <= '0;
            poff_reg   <= 8'd4;
        end else if (accept) begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            aflags_reg <= aflags_next;
            eflags_reg <= eflags_next;
            ctl_reg    <= ctl_next;
            left_reg   <= left_next;
            poff_reg   <= poff_next;
        end
    end

endmodule

>>> rtl/core/ts_pfp_emit.sv
// Result buffer: holds one byte's fields and shifts them out one word a cycle while m_ready is high
module ts_pfp_emit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  ts_pfp_pkg::run_t   run,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output ts_pfp_pkg::field_t head,
    output logic               last
);

    ts_pfp_pkg::field_t [ts_pfp_pkg::MAX_RESULTS-1:0] buf_reg, buf_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       fire;

    assign m_valid = (cnt_reg != 4'd0);
    assign fire    = m_valid && m_ready;
    assign last    = (cnt_reg == 4'd1);
    assign head    = buf_reg[0];
    // Free when empty or when the final field leaves this cycle
    assign free    = !m_valid || (fire && last);

    // Load a new run or shift toward the head
    always_comb begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load) begin
            buf_next = run.fields;
            cnt_next = run.count;
        end else if (fire) begin
            for (int i = 0; i < ts_pfp_pkg::MAX_RESULTS - 1; i++) begin
                buf_next[i] = buf_reg[i+1];
            end
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/core/ts_pfp_checker.sv
// Port-level checks of the field parser, bound to the top level
`include "ts_packet_field_parser_assert.svh"

module ts_pfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_packet_start,
    input logic        m_valid,
    input logic        m_ready,
    input logic [5:0]  m_field_code,
    input logic        m_last_of_run
);

    // Buffer empties on reset
    `TPFP_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "output valid after reset")

    // Codes stay in range
    `TPFP_ASSERT(a_code_range, aclk, aresetn, m_valid |-> m_field_code <= ts_pfp_pkg::FC_SYNC_ERR, "field code out of range")

    // Start byte yields exactly one sync or sync error word next
    `TPFP_ASSERT(a_start_run, aclk, aresetn, (s_valid && s_ready && s_packet_start) |=> (m_valid && m_last_of_run && (m_field_code == ts_pfp_pkg::FC_SYNC || m_field_code == ts_pfp_pkg::FC_SYNC_ERR)), "start byte run wrong")

    // Stalled word holds
    `TPFP_ASSERT(a_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_field_code)), "stalled word changed")

endmodule

bind ts_packet_field_parser ts_pfp_checker u_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_packet_start (s_packet_start),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_field_code   (m_field_code),
    .m_last_of_run  (m_last_of_run)
);
